@@ hdl/nls_pkg.sv @@
// Package for the number literal scanner: scan phases, outcome codes, register
// indexes, character constants, beat structs and small character-class functions.
// No dependencies.
package nls_pkg;

    // Lengths saturate here; the reported length is 10 bits wide.
    localparam int unsigned MAX_LENGTH = 1023;
    localparam int unsigned LEN_W      = 10;
    localparam int unsigned COL_W      = 10;
    localparam int unsigned RCOL_W     = 11;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LENGTH);

    // Scan modes.
    localparam logic [1:0] MODE_INT   = 2'd0;
    localparam logic [1:0] MODE_FLOAT = 2'd1;
    localparam logic [1:0] MODE_OCTAL = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SCAN_MODE  = 2'd0;
    localparam logic [1:0] REG_LOOK_AHEAD = 2'd1;
    localparam logic [1:0] REG_REQ_COLUMN = 2'd2;
    localparam logic [1:0] REG_NEED_FNS   = 2'd3;

    // A required column of minus one lets a scan start in any column.
    localparam logic signed [RCOL_W-1:0] ANY_COLUMN = -11'sd1;

    // Characters the scanner recognises.
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_E_LOW  = 8'h65;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SUF_L  = 8'h4C;
    localparam logic [7:0] CH_SUF_U  = 8'h55;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_INT,
        PH_FINT,
        PH_FFRAC,
        PH_FE,
        PH_FSIGN,
        PH_FEXP,
        PH_OSTART,
        PH_OZERO,
        PH_ODIG
    } phase_t;

    typedef enum logic [1:0] {
        OUT_GO_ON,
        OUT_ACCEPT,
        OUT_REJECT
    } outcome_t;

    typedef struct packed {
        logic [1:0]               scan_mode;
        logic                     look_ahead;
        logic signed [RCOL_W-1:0] required_column;
        logic                     need_first_non_space;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       char_byte;
        logic             scan_start;
        logic             text_end;
        logic [COL_W-1:0] start_column;
        logic             at_word_start;
        logic             at_first_non_space;
    } item_t;

    typedef struct packed {
        logic             matched;
        logic [LEN_W-1:0] match_length;
    } result_t;

    function automatic logic is_dec(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_SEVEN]};
    endfunction

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
        return (v == LEN_MAX) ? v : v + LEN_W'(1);
    endfunction

endpackage

@@ hdl/number_literal_scanner.sv @@
// Number literal scanner: detects integer, float and C octal literals in a byte stream.
// Top level, depends on nls_pkg, nls_cfg_regs and nls_scan_step.
//
// Usage. Text enters one byte per beat on the s_ channel: s_tuser marks the byte that
// opens a new scan, s_tlast the last byte of available text, and s_tdata carries the
// byte with the column, word-start and first-non-space flags read on the opening byte.
// A scan gets one result beat on the m_ channel as soon as its outcome is known: at the
// first byte that cannot extend the literal, at a byte marked last, or at once when the
// opening byte fails a gate. A scan abandoned by a new opening byte gives no result,
// and neither do bytes outside a scan.
// Timing. An accepted beat lands in the input register; its result, if any, enters the
// output register (m_tvalid) once that register is free or being emptied. The grammar
// step is one pass of logic between the registers, and a byte is taken every cycle
// while m_tready stays high. When the receiver stalls, the output register holds its
// beat; the input register can still take one more byte, after which s_tready falls
// until the output beat is taken. Reset (aresetn low, synchronous) empties both
// registers, closes any scan and loads the register defaults: integer mode, no
// look-ahead, any column, no first-non-space requirement. The user must write registers
// over the APB-style port only while the stream is idle; the block does not check this.
module number_literal_scanner
    import nls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] char_byte, [17:8] start_column, [18] at_word_start,
    // [19] at_first_non_space, [23:20] zero
    input  logic [23:0] s_tdata,
    // [0] scan_start
    input  logic [0:0]  s_tuser,
    // text_end
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] matched, [10:1] match_length, [15:11] zero
    output logic [15:0] m_tdata
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res;
    logic    res_valid;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    s_fire;

    nls_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nls_scan_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item       (in_item_reg),
        .item_valid (in_valid_reg),
        .step_en    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    // The held byte moves on whenever the output register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.char_byte          <= s_tdata[7:0];
            in_item_reg.scan_start         <= s_tuser[0];
            in_item_reg.text_end           <= s_tlast;
            in_item_reg.start_column       <= s_tdata[17:8];
            in_item_reg.at_word_start      <= s_tdata[18];
            in_item_reg.at_first_non_space <= s_tdata[19];
        end
    end

    // Output register: loaded on every step, cleared once its beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.match_length, out_reg.matched};

endmodule

@@ hdl/nls_cfg_regs.sv @@
// Configuration register file of the number literal scanner on an APB-style port.
// Depends on nls_pkg for the register indexes and the configuration struct.
module nls_cfg_regs
    import nls_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_mode            <= MODE_INT;
            cfg_reg.look_ahead           <= 1'b0;
            cfg_reg.required_column      <= ANY_COLUMN;
            cfg_reg.need_first_non_space <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SCAN_MODE:  cfg_reg.scan_mode            <= pwdata[1:0];
                REG_LOOK_AHEAD: cfg_reg.look_ahead           <= pwdata[0];
                REG_REQ_COLUMN: cfg_reg.required_column      <= $signed(pwdata[RCOL_W-1:0]);
                REG_NEED_FNS:   cfg_reg.need_first_non_space <= pwdata[0];
                default:        cfg_reg.scan_mode            <= cfg_reg.scan_mode;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SCAN_MODE:  prdata = {30'd0, cfg_reg.scan_mode};
            REG_LOOK_AHEAD: prdata = {31'd0, cfg_reg.look_ahead};
            REG_REQ_COLUMN: prdata = {{(32-RCOL_W){cfg_reg.required_column[RCOL_W-1]}},
                                      cfg_reg.required_column};
            REG_NEED_FNS:   prdata = {31'd0, cfg_reg.need_first_non_space};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

@@ hdl/nls_scan_step.sv @@
// Scan state and per-byte step logic of the number literal scanner.
// Depends on nls_pkg for phases, outcomes, structs and character classes.
module nls_scan_step
    import nls_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    item_valid,
    input  logic    step_en,
    output logic    res_valid,
    output result_t res
);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             digit_reg, digit_next;

    phase_t           init_phase;
    phase_t           cur_phase;
    phase_t           feed_phase;
    logic [LEN_W-1:0] cur_len;
    logic             cur_digit;
    logic             mode_ok;
    logic             word_needed;
    logic             col_ok;
    logic             gate_fail;
    logic             active;
    logic             bump;
    logic             set_digit;
    logic             new_digit;
    logic [LEN_W-1:0] len_after;
    outcome_t         feed_out;
    outcome_t         final_out;

    // Start-of-scan phase and gates.
    always_comb begin
        mode_ok     = 1'b1;
        word_needed = 1'b0;
        case (cfg.scan_mode)
            MODE_INT: begin
                init_phase  = PH_INT;
                word_needed = 1'b1;
            end
            MODE_FLOAT: begin
                init_phase  = PH_FINT;
                word_needed = 1'b1;
            end
            MODE_OCTAL: begin
                init_phase  = PH_OSTART;
            end
            default: begin
                init_phase  = PH_IDLE;
                mode_ok     = 1'b0;
            end
        endcase
    end

    assign col_ok = (cfg.required_column == ANY_COLUMN) ||
                    (cfg.required_column == $signed({1'b0, item.start_column}));

    assign gate_fail = item.scan_start &&
                       (!col_ok || !mode_ok ||
                        (cfg.need_first_non_space && !item.at_first_non_space) ||
                        (word_needed && !item.at_word_start));

    assign active    = item.scan_start || (phase_reg != PH_IDLE);
    assign cur_phase = item.scan_start ? init_phase : phase_reg;
    assign cur_len   = item.scan_start ? '0 : len_reg;
    assign cur_digit = item.scan_start ? 1'b0 : digit_reg;

    // One byte through the literal grammar.
    always_comb begin
        feed_phase = cur_phase;
        bump       = 1'b0;
        set_digit  = 1'b0;
        feed_out   = OUT_REJECT;
        case (cur_phase)
            PH_INT: begin
                if (is_dec(item.char_byte)) begin
                    bump      = 1'b1;
                    set_digit = 1'b1;
                    feed_out  = OUT_GO_ON;
                end else begin
                    feed_out  = cur_digit ? OUT_ACCEPT : OUT_REJECT;
                end
            end
            PH_FINT, PH_FFRAC: begin
                if (is_dec(item.char_byte)) begin
                    bump      = 1'b1;
                    set_digit = 1'b1;
                    feed_out  = OUT_GO_ON;
                end else if (cur_phase == PH_FINT && item.char_byte == CH_POINT) begin
                    bump       = 1'b1;
                    feed_phase = PH_FFRAC;
                    feed_out   = OUT_GO_ON;
                end else if (item.char_byte == CH_E_LOW || item.char_byte == CH_E_UP) begin
                    // An exponent with no mantissa digit before it is refused.
                    if (cur_digit) begin
                        bump       = 1'b1;
                        feed_phase = PH_FE;
                        feed_out   = OUT_GO_ON;
                    end
                end else if (cur_phase == PH_FFRAC) begin
                    feed_out = cur_digit ? OUT_ACCEPT : OUT_REJECT;
                end
            end
            PH_FE: begin
                if (item.char_byte == CH_PLUS || item.char_byte == CH_MINUS) begin
                    bump       = 1'b1;
                    feed_phase = PH_FSIGN;
                    feed_out   = OUT_GO_ON;
                end else if (is_dec(item.char_byte)) begin
                    bump       = 1'b1;
                    feed_phase = PH_FEXP;
                    feed_out   = OUT_GO_ON;
                end
            end
            PH_FSIGN: begin
                if (is_dec(item.char_byte)) begin
                    bump       = 1'b1;
                    feed_phase = PH_FEXP;
                    feed_out   = OUT_GO_ON;
                end
            end
            PH_FEXP: begin
                if (is_dec(item.char_byte)) begin
                    bump     = 1'b1;
                    feed_out = OUT_GO_ON;
                end else begin
                    feed_out = OUT_ACCEPT;
                end
            end
            PH_OSTART: begin
                if (item.char_byte == CH_ZERO) begin
                    bump       = 1'b1;
                    feed_phase = PH_OZERO;
                    feed_out   = OUT_GO_ON;
                end
            end
            PH_OZERO: begin
                if (is_oct(item.char_byte)) begin
                    bump       = 1'b1;
                    feed_phase = PH_ODIG;
                    feed_out   = OUT_GO_ON;
                end
            end
            PH_ODIG: begin
                if (is_oct(item.char_byte)) begin
                    bump     = 1'b1;
                    feed_out = OUT_GO_ON;
                end else if (item.char_byte == CH_SUF_L || item.char_byte == CH_SUF_U) begin
                    // The suffix belongs to the literal and closes it.
                    bump     = 1'b1;
                    feed_out = OUT_ACCEPT;
                end else begin
                    feed_out = OUT_ACCEPT;
                end
            end
            default: begin
                feed_out = OUT_REJECT;
            end
        endcase
    end

    assign new_digit = cur_digit | set_digit;
    assign len_after = bump ? sat_inc(cur_len) : cur_len;

    // A scan still open on the last byte of text is decided there.
    always_comb begin
        final_out = feed_out;
        if (feed_out == OUT_GO_ON && item.text_end) begin
            case (feed_phase)
                PH_INT, PH_FFRAC: final_out = new_digit ? OUT_ACCEPT : OUT_REJECT;
                PH_FEXP, PH_ODIG: final_out = OUT_ACCEPT;
                default:          final_out = OUT_REJECT;
            endcase
        end
    end

    assign res_valid = item_valid && active && (gate_fail || final_out != OUT_GO_ON);

    always_comb begin
        res.matched      = !gate_fail && (final_out == OUT_ACCEPT);
        res.match_length = (res.matched && !cfg.look_ahead) ? len_after : '0;
    end

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        digit_next = digit_reg;
        if (step_en && item_valid && active) begin
            if (gate_fail || final_out != OUT_GO_ON) begin
                phase_next = PH_IDLE;
            end else begin
                phase_next = feed_phase;
                len_next   = len_after;
                digit_next = new_digit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            digit_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            digit_reg <= digit_next;
        end
    end

`ifndef ASSERT_OFF
    a_fail_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res.matched |-> res.match_length == '0)
        else $error("unmatched result carries a non-zero length");

    a_look_ahead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && cfg.look_ahead |-> res.match_length == '0)
        else $error("look-ahead result carries a non-zero length");

    a_closed_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res_valid |=> phase_reg == PH_IDLE)
        else $error("scan still open after its result");

    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE && !item.scan_start |-> !res_valid)
        else $error("result produced with no open scan");
`endif

endmodule
